// ===== rtl/bi5d_pkg.sv =====
`timescale 1ns / 1ps
package bi5d_pkg;

  localparam int NUM_DIMS         = 5;
  localparam int SIZE_BITS        = 16;
  localparam int CFG_DATA_BITS    = 32;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int COORD_BITS_DEF   = 16;
  localparam int RESULT_BITS_DEF  = 48;

  localparam logic [31:0] DATA_SIZE_LO_RST  = 32'h0001_0001;
  localparam logic [31:0] DATA_SIZE_MID_RST = 32'h0001_0001;
  localparam logic [15:0] DATA_SIZE_TOP_RST = 16'd1;
  localparam logic [31:0] TILE_SIZE_LO_RST  = 32'h0001_0001;
  localparam logic [31:0] TILE_SIZE_MID_RST = 32'h0001_0001;
  localparam logic [15:0] TILE_SIZE_TOP_RST = 16'd1;
  localparam logic [14:0] DIM_ORDER_RST     = 15'd18056;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DATA_SIZE_LO,
    REG_DATA_SIZE_MID,
    REG_DATA_SIZE_TOP,
    REG_TILE_SIZE_LO,
    REG_TILE_SIZE_MID,
    REG_TILE_SIZE_TOP,
    REG_DIM_ORDER
  } bi5d_reg_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BAD,
    STAT_OVF
  } bi5d_status_t;

  typedef struct packed {
    logic mode;
    logic bad;
  } bi5d_side_t;

endpackage

// ===== rtl/block_index_5d_core.sv =====
`timescale 1ns / 1ps
// Linear block number of a voxel in a blocked 5-D volume (with in_mode high, the total
// block count). A request is taken on any cycle with start high (busy stays low), one
// request per clock, and its result appears on out_valid in request order, after the entry
// register, the bit-per-stage divider pipeline that forms the block indices and block
// counts, and seven multiply and add stages. Results cannot be held off: sample them in
// the out_valid cycle. Write configuration only with no request in flight.
module block_index_5d_core #(
  parameter int COORD_BITS  = bi5d_pkg::COORD_BITS_DEF,
  parameter int RESULT_BITS = bi5d_pkg::RESULT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_mode,
  input  logic [COORD_BITS-1:0]                  in_coord_x,
  input  logic [COORD_BITS-1:0]                  in_coord_y,
  input  logic [COORD_BITS-1:0]                  in_coord_z,
  input  logic [COORD_BITS-1:0]                  in_coord_channel,
  input  logic [COORD_BITS-1:0]                  in_coord_time,
  output logic                                   out_valid,
  output logic [RESULT_BITS-1:0]                 out_block_number,
  output logic [1:0]                             out_status,
  input  logic                                   cfg_we,
  input  logic [bi5d_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [bi5d_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

  localparam int ND    = bi5d_pkg::NUM_DIMS;
  localparam int SB    = bi5d_pkg::SIZE_BITS;
  localparam int DivW  = (COORD_BITS > SB + 1) ? COORD_BITS : SB + 1;
  localparam int LANES = 2 * ND;

  logic [31:0] data_size_lo_r, data_size_mid_r, tile_size_lo_r, tile_size_mid_r;
  logic [15:0] data_size_top_r, tile_size_top_r;
  logic [14:0] dim_order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_size_lo_r  <= bi5d_pkg::DATA_SIZE_LO_RST;
      data_size_mid_r <= bi5d_pkg::DATA_SIZE_MID_RST;
      data_size_top_r <= bi5d_pkg::DATA_SIZE_TOP_RST;
      tile_size_lo_r  <= bi5d_pkg::TILE_SIZE_LO_RST;
      tile_size_mid_r <= bi5d_pkg::TILE_SIZE_MID_RST;
      tile_size_top_r <= bi5d_pkg::TILE_SIZE_TOP_RST;
      dim_order_r     <= bi5d_pkg::DIM_ORDER_RST;
    end else if (cfg_we) begin
      unique case (bi5d_pkg::bi5d_reg_t'(cfg_index))
        bi5d_pkg::REG_DATA_SIZE_LO:  data_size_lo_r  <= cfg_wdata;
        bi5d_pkg::REG_DATA_SIZE_MID: data_size_mid_r <= cfg_wdata;
        bi5d_pkg::REG_DATA_SIZE_TOP: data_size_top_r <= cfg_wdata[15:0];
        bi5d_pkg::REG_TILE_SIZE_LO:  tile_size_lo_r  <= cfg_wdata;
        bi5d_pkg::REG_TILE_SIZE_MID: tile_size_mid_r <= cfg_wdata;
        bi5d_pkg::REG_TILE_SIZE_TOP: tile_size_top_r <= cfg_wdata[15:0];
        bi5d_pkg::REG_DIM_ORDER:     dim_order_r     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  logic [ND-1:0][SB-1:0]         size_c, tile_c;
  logic [ND-1:0][COORD_BITS-1:0] axis_coord;
  logic [LANES-1:0][DivW-1:0]    dividend_nxt;
  logic [LANES-1:0][SB-1:0]      divisor_nxt;
  logic                          bad_nxt;

  assign size_c     = {data_size_top_r, data_size_mid_r, data_size_lo_r};
  assign tile_c     = {tile_size_top_r, tile_size_mid_r, tile_size_lo_r};
  assign axis_coord = {in_coord_time, in_coord_channel, in_coord_z, in_coord_y, in_coord_x};

  always_comb begin
    logic [ND-1:0] seen;
    logic [2:0]    ax;
    seen    = '0;
    ax      = '0;
    bad_nxt = 1'b0;
    for (int k = 0; k < ND; k++) begin
      ax = dim_order_r[3*k +: 3];
      if (ax >= 3'(ND)) begin
        bad_nxt = 1'b1;
      end else if (seen[ax]) begin
        bad_nxt = 1'b1;
      end else begin
        seen[ax] = 1'b1;
      end
      if (size_c[k] == '0 || tile_c[k] == '0) begin
        bad_nxt = 1'b1;
      end
      if (in_mode) begin
        dividend_nxt[k] = DivW'(size_c[k] - 16'd1);
      end else if (ax < 3'(ND)) begin
        dividend_nxt[k] = DivW'(axis_coord[ax]);
      end else begin
        dividend_nxt[k] = '0;
      end
      dividend_nxt[ND+k] = DivW'({1'b0, size_c[k]} + {1'b0, tile_c[k]} - 17'd1);
      divisor_nxt[k]     = tile_c[k];
      divisor_nxt[ND+k]  = tile_c[k];
    end
  end

  logic                          ent_valid_r;
  bi5d_pkg::bi5d_side_t          ent_side_r;
  logic [LANES-1:0][DivW-1:0]    ent_dividend_r;
  logic [LANES-1:0][SB-1:0]      ent_divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ent_side_r.mode <= in_mode;
    ent_side_r.bad  <= bad_nxt;
    ent_dividend_r  <= dividend_nxt;
    ent_divisor_r   <= divisor_nxt;
  end

  logic                          div_valid;
  bi5d_pkg::bi5d_side_t          div_side;
  logic [LANES-1:0][DivW-1:0]    div_quot;

  bi5d_div_pipe #(
    .DW    (DivW),
    .LANES (LANES)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (ent_valid_r),
    .in_side     (ent_side_r),
    .in_dividend (ent_dividend_r),
    .in_divisor  (ent_divisor_r),
    .out_valid   (div_valid),
    .out_side    (div_side),
    .out_quot    (div_quot)
  );

  bi5d_accum #(
    .DW          (DivW),
    .RESULT_BITS (RESULT_BITS)
  ) u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (div_valid),
    .in_side          (div_side),
    .in_q             (div_quot[ND-1:0]),
    .in_n             (div_quot[LANES-1:ND]),
    .out_valid        (out_valid),
    .out_block_number (out_block_number),
    .out_status       (out_status)
  );

  assign busy = 1'b0;

endmodule

// ===== rtl/bi5d_div_pipe.sv =====
`timescale 1ns / 1ps
module bi5d_div_pipe #(
  parameter int DW    = 17,
  parameter int LANES = 10
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  input  bi5d_pkg::bi5d_side_t                       in_side,
  input  logic [LANES-1:0][DW-1:0]                   in_dividend,
  input  logic [LANES-1:0][bi5d_pkg::SIZE_BITS-1:0]  in_divisor,
  output logic                                       out_valid,
  output bi5d_pkg::bi5d_side_t                       out_side,
  output logic [LANES-1:0][DW-1:0]                   out_quot
);

  localparam int SB = bi5d_pkg::SIZE_BITS;

  // one quotient bit per stage; stage s result lands in index s
  logic                        v_r      [DW];
  bi5d_pkg::bi5d_side_t        side_r   [DW];
  logic [LANES-1:0][SB-1:0]    rem_r    [DW-1];
  logic [LANES-1:0][DW-1:0]    dq_r     [DW];
  logic [LANES-1:0][SB-1:0]    dv_r     [DW];
  logic [LANES-1:0][SB-1:0]    rem_nxt  [DW-1];
  logic [LANES-1:0][DW-1:0]    dq_nxt   [DW];

  function automatic logic [SB:0] div_step(logic [SB-1:0] rem, logic msb, logic [SB-1:0] dv);
    logic [SB:0] trial;
    trial = {rem, msb};
    if (trial >= {1'b0, dv}) begin
      div_step = {SB'(trial - {1'b0, dv}), 1'b1};
    end else begin
      div_step = {trial[SB-1:0], 1'b0};
    end
  endfunction

  always_comb begin
    logic [SB:0] r;
    r = '0;
    for (int l = 0; l < LANES; l++) begin
      r = div_step('0, in_dividend[l][DW-1], in_divisor[l]);
      rem_nxt[0][l] = r[SB:1];
      dq_nxt[0][l]  = {in_dividend[l][DW-2:0], r[0]};
    end
    for (int s = 1; s < DW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        r = div_step(rem_r[s-1][l], dq_r[s-1][l][DW-1], dv_r[s-1][l]);
        if (s < DW - 1) begin
          rem_nxt[s][l] = r[SB:1];
        end
        dq_nxt[s][l] = {dq_r[s-1][l][DW-2:0], r[0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DW; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      v_r[0] <= in_valid;
      for (int s = 1; s < DW; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    dq_r[0]   <= dq_nxt[0];
    dv_r[0]   <= in_divisor;
    for (int s = 0; s < DW - 1; s++) begin
      rem_r[s] <= rem_nxt[s];
    end
    for (int s = 1; s < DW; s++) begin
      side_r[s] <= side_r[s-1];
      dq_r[s]   <= dq_nxt[s];
      dv_r[s]   <= dv_r[s-1];
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_side  = side_r[DW-1];
  assign out_quot  = dq_r[DW-1];

endmodule

// ===== rtl/bi5d_accum.sv =====
`timescale 1ns / 1ps
module bi5d_accum #(
  parameter int DW          = 17,
  parameter int RESULT_BITS = 48
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  bi5d_pkg::bi5d_side_t                          in_side,
  input  logic [bi5d_pkg::NUM_DIMS-1:0][DW-1:0]         in_q,
  input  logic [bi5d_pkg::NUM_DIMS-1:0][DW-1:0]         in_n,
  output logic                                          out_valid,
  output logic [RESULT_BITS-1:0]                        out_block_number,
  output logic [1:0]                                    out_status
);

  localparam int ND = bi5d_pkg::NUM_DIMS;
  localparam int SB = bi5d_pkg::SIZE_BITS;
  localparam logic [64:0] LIM65 = (65'd1 << RESULT_BITS) - 65'd1;
  localparam logic [63:0] LIM   = LIM65[63:0];

  // stage 1: unit of dims 1 and 2
  logic                         v1_r;
  bi5d_pkg::bi5d_side_t         side1_r;
  logic [ND-1:0][DW-1:0]        q1_r;
  logic [SB-1:0]                u1_1_r, n2_1_r, n3_1_r;
  logic [2*SB-1:0]              u2_1_r;
  // stage 2
  logic                         v2_r;
  bi5d_pkg::bi5d_side_t         side2_r;
  logic [ND-1:0][DW-1:0]        q2_r;
  logic [SB-1:0]                u1_2_r, n3_2_r;
  logic [2*SB-1:0]              u2_2_r;
  logic [3*SB-1:0]              u3_2_r;
  // stage 3
  logic                         v3_r;
  bi5d_pkg::bi5d_side_t         side3_r;
  logic [ND-1:0][DW-1:0]        q3_r;
  logic [ND-1:0][63:0]          u3_r;
  // stage 4
  logic                         v4_r;
  bi5d_pkg::bi5d_side_t         side4_r;
  logic [ND-1:0][63:0]          ml4_r, mh4_r;
  logic [ND-1:0]                uo4_r, qnz4_r;
  // stage 5
  logic                         v5_r;
  bi5d_pkg::bi5d_side_t         side5_r;
  logic [ND-1:0][63:0]          t5_r;
  logic                         ovf5_r;
  // stage 6
  logic                         v6_r;
  bi5d_pkg::bi5d_side_t         side6_r;
  logic [64:0]                  s01_6_r, s23_6_r, s4_6_r;
  logic                         ovf6_r;
  // output
  logic                         out_valid_r;
  logic [RESULT_BITS-1:0]       block_number_r;
  logic [1:0]                   status_r;

  logic [ND-1:0][63:0]          ml4_nxt, mh4_nxt;
  logic [ND-1:0]                uo4_nxt, qnz4_nxt;
  logic [ND-1:0][63:0]          t5_nxt;
  logic                         ovf5_nxt;
  logic [66:0]                  tot_nxt;

  always_comb begin
    logic [31:0] qx;
    qx = '0;
    for (int k = 0; k < ND; k++) begin
      qx          = 32'(q3_r[k]);
      ml4_nxt[k]  = qx * u3_r[k][31:0];
      mh4_nxt[k]  = qx * u3_r[k][63:32];
      uo4_nxt[k]  = u3_r[k] > LIM;
      qnz4_nxt[k] = q3_r[k] != '0;
    end
  end

  always_comb begin
    logic [95:0] prod;
    prod     = '0;
    ovf5_nxt = 1'b0;
    for (int k = 0; k < ND; k++) begin
      prod      = {mh4_r[k], 32'd0} + {32'd0, ml4_r[k]};
      t5_nxt[k] = prod[63:0];
      if (qnz4_r[k] && (uo4_r[k] || prod > {32'd0, LIM})) begin
        ovf5_nxt = 1'b1;
      end
    end
  end

  assign tot_nxt = {2'b00, s01_6_r} + {2'b00, s23_6_r} + {2'b00, s4_6_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= in_side;
    q1_r    <= in_q;
    u1_1_r  <= in_n[0][SB-1:0];
    n2_1_r  <= in_n[2][SB-1:0];
    n3_1_r  <= in_n[3][SB-1:0];
    u2_1_r  <= in_n[0][SB-1:0] * in_n[1][SB-1:0];

    side2_r <= side1_r;
    q2_r    <= q1_r;
    u1_2_r  <= u1_1_r;
    n3_2_r  <= n3_1_r;
    u2_2_r  <= u2_1_r;
    u3_2_r  <= u2_1_r * n2_1_r;

    side3_r  <= side2_r;
    q3_r     <= q2_r;
    u3_r[0]  <= 64'd1;
    u3_r[1]  <= 64'(u1_2_r);
    u3_r[2]  <= 64'(u2_2_r);
    u3_r[3]  <= 64'(u3_2_r);
    u3_r[4]  <= u3_2_r * n3_2_r;

    side4_r <= side3_r;
    ml4_r   <= ml4_nxt;
    mh4_r   <= mh4_nxt;
    uo4_r   <= uo4_nxt;
    qnz4_r  <= qnz4_nxt;

    side5_r <= side4_r;
    t5_r    <= t5_nxt;
    ovf5_r  <= ovf5_nxt;

    side6_r <= side5_r;
    s01_6_r <= {1'b0, t5_r[0]} + {1'b0, t5_r[1]};
    s23_6_r <= {1'b0, t5_r[2]} + {1'b0, t5_r[3]};
    s4_6_r  <= {1'b0, t5_r[4]} + 65'(side5_r.mode);
    ovf6_r  <= ovf5_r;

    if (side6_r.bad) begin
      block_number_r <= '0;
      status_r       <= bi5d_pkg::STAT_BAD;
    end else if (ovf6_r || tot_nxt > {3'b000, LIM}) begin
      block_number_r <= LIM[RESULT_BITS-1:0];
      status_r       <= bi5d_pkg::STAT_OVF;
    end else begin
      block_number_r <= tot_nxt[RESULT_BITS-1:0];
      status_r       <= bi5d_pkg::STAT_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_number = block_number_r;
  assign out_status       = status_r;

endmodule

// ===== rtl/bi5d_checker.sv =====
`timescale 1ns / 1ps
module bi5d_checker #(
  parameter int RESULT_BITS = bi5d_pkg::RESULT_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   busy,
  input logic                   out_valid,
  input logic [RESULT_BITS-1:0] out_block_number,
  input logic [1:0]             out_status
);

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bi5d_pkg::STAT_OK || out_status == bi5d_pkg::STAT_BAD ||
                   out_status == bi5d_pkg::STAT_OVF))
    else $error("undefined status code");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bi5d_pkg::STAT_BAD) |-> out_block_number == '0)
    else $error("bad config result not zero");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bi5d_pkg::STAT_OVF) |-> (&out_block_number))
    else $error("overflow result not saturated");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind block_index_5d_core bi5d_checker #(
  .RESULT_BITS (RESULT_BITS)
) u_bi5d_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_block_number (out_block_number),
  .out_status       (out_status)
);

// ===== verif/block_index_5d_core_tb.sv =====
`timescale 1ns / 1ps
module block_index_5d_core_tb;

  localparam int CB = 16;
  localparam int RB = 48;
  localparam longint unsigned NUM_MAX = (64'd1 << RB) - 1;
  localparam int LATENCY = 25;

  typedef struct {
    logic [RB-1:0] block_number;
    logic [1:0]    status;
  } blk_result_t;

  class blk_scoreboard;
    blk_result_t pending[$];
    int errors;
    int checked;
    logic [15:0] dsize[5];
    logic [15:0] tsize[5];
    logic [14:0] order;

    function new();
      for (int k = 0; k < 5; k++) begin
        dsize[k] = 16'd1;
        tsize[k] = 16'd1;
      end
      order = bi5d_pkg::DIM_ORDER_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(bi5d_pkg::bi5d_reg_t idx, logic [31:0] v);
      case (idx)
        bi5d_pkg::REG_DATA_SIZE_LO: begin
          dsize[0] = v[15:0]; dsize[1] = v[31:16];
        end
        bi5d_pkg::REG_DATA_SIZE_MID: begin
          dsize[2] = v[15:0]; dsize[3] = v[31:16];
        end
        bi5d_pkg::REG_DATA_SIZE_TOP: dsize[4] = v[15:0];
        bi5d_pkg::REG_TILE_SIZE_LO: begin
          tsize[0] = v[15:0]; tsize[1] = v[31:16];
        end
        bi5d_pkg::REG_TILE_SIZE_MID: begin
          tsize[2] = v[15:0]; tsize[3] = v[31:16];
        end
        bi5d_pkg::REG_TILE_SIZE_TOP: tsize[4] = v[15:0];
        bi5d_pkg::REG_DIM_ORDER: order = v[14:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic mode, logic [CB-1:0] crd[5]);
      blk_result_t r;
      bit bad, ovf, unit_ovf;
      logic [4:0] seen;
      int ax;
      longint unsigned unit, sum, q, n, term, c;
      bad = 0; ovf = 0; unit_ovf = 0; seen = '0;
      unit = 1; sum = 0;
      for (int k = 0; k < 5; k++) begin
        ax = int'(order[3*k +: 3]);
        if (ax > 4 || seen[ax]) bad = 1;
        else seen[ax] = 1;
        if (dsize[k] == 0 || tsize[k] == 0) bad = 1;
      end
      if (bad) begin
        r.block_number = '0;
        r.status = bi5d_pkg::STAT_BAD;
      end else begin
        for (int k = 0; k < 5; k++) begin
          ax = int'(order[3*k +: 3]);
          c = mode ? 64'(dsize[k]) - 64'd1 : 64'(crd[ax]);
          q = c / 64'(tsize[k]);
          n = (64'(dsize[k]) + 64'(tsize[k]) - 64'd1) / 64'(tsize[k]);
          if (q != 0) begin
            if (unit_ovf || q > NUM_MAX / unit) begin
              ovf = 1; term = NUM_MAX;
            end else term = q * unit;
            if (term > NUM_MAX - sum) begin
              ovf = 1; sum = NUM_MAX;
            end else sum = sum + term;
          end
          if (n > NUM_MAX / unit) begin
            unit_ovf = 1; unit = NUM_MAX;
          end else unit = unit * n;
        end
        if (mode) begin
          if (sum == NUM_MAX) ovf = 1;
          else sum = sum + 1;
        end
        r.block_number = ovf ? NUM_MAX[RB-1:0] : sum[RB-1:0];
        r.status = ovf ? bi5d_pkg::STAT_OVF : bi5d_pkg::STAT_OK;
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [RB-1:0] num, logic [1:0] st);
      blk_result_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result num=%h status=%0d", num, st);
        return;
      end
      e = pending.pop_front();
      if (num !== e.block_number || st !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp num=%h st=%0d got num=%h st=%0d",
                   e.block_number, e.status, num, st);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_mode = 0;
  logic [CB-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [CB-1:0] in_coord_channel = '0, in_coord_time = '0;
  logic out_valid;
  logic [RB-1:0] out_block_number;
  logic [1:0] out_status;
  logic cfg_we = 0;
  logic [bi5d_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [bi5d_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  blk_scoreboard sb = new();
  bit idle_on = 1;
  int n_req = 0;
  int n_mode1 = 0;

  always #5 clk = ~clk;

  block_index_5d_core u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_block_number, out_status);
  end

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_request(logic mode, logic [CB-1:0] crd[5]);
    idle_gap();
    start <= 1;
    in_mode <= mode;
    in_coord_x <= crd[0];
    in_coord_y <= crd[1];
    in_coord_z <= crd[2];
    in_coord_channel <= crd[3];
    in_coord_time <= crd[4];
    do @(posedge clk); while (busy);
    sb.note_request(mode, crd);
    n_req++;
    if (mode) n_mode1++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_cfg(bi5d_pkg::bi5d_reg_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic random_request();
    logic [CB-1:0] crd[5];
    for (int k = 0; k < 5; k++) begin
      case ($urandom_range(0, 3))
        0: crd[k] = '0;
        1: crd[k] = '1;
        2: crd[k] = 16'($urandom_range(0, 255));
        default: crd[k] = 16'($urandom);
      endcase
    end
    send_request($urandom_range(0, 4) == 0, crd);
  endtask

  task automatic random_config(int kind);
    logic [14:0] ord;
    int perm[5];
    for (int k = 0; k < 5; k++) perm[k] = k;
    for (int k = 4; k > 0; k--) begin
      int j, t;
      j = $urandom_range(0, k);
      t = perm[k]; perm[k] = perm[j]; perm[j] = t;
    end
    for (int k = 0; k < 5; k++) ord[3*k +: 3] = 3'(perm[k]);
    if (kind == 0) ord = 15'($urandom);
    write_cfg(bi5d_pkg::REG_DIM_ORDER, 32'(ord));
    case (kind % 4)
      1: begin
        write_cfg(bi5d_pkg::REG_DATA_SIZE_LO,
                  {16'($urandom_range(1, 300)), 16'($urandom_range(1, 300))});
        write_cfg(bi5d_pkg::REG_DATA_SIZE_MID,
                  {16'($urandom_range(1, 300)), 16'($urandom_range(1, 300))});
        write_cfg(bi5d_pkg::REG_DATA_SIZE_TOP, $urandom_range(1, 300));
        write_cfg(bi5d_pkg::REG_TILE_SIZE_LO,
                  {16'($urandom_range(1, 40)), 16'($urandom_range(1, 40))});
        write_cfg(bi5d_pkg::REG_TILE_SIZE_MID,
                  {16'($urandom_range(1, 40)), 16'($urandom_range(1, 40))});
        write_cfg(bi5d_pkg::REG_TILE_SIZE_TOP, $urandom_range(1, 40));
      end
      2: begin
        write_cfg(bi5d_pkg::REG_DATA_SIZE_LO, $urandom | 32'h0001_0001);
        write_cfg(bi5d_pkg::REG_DATA_SIZE_MID, $urandom | 32'h0001_0001);
        write_cfg(bi5d_pkg::REG_DATA_SIZE_TOP, $urandom | 32'd1);
        write_cfg(bi5d_pkg::REG_TILE_SIZE_LO, $urandom);
        write_cfg(bi5d_pkg::REG_TILE_SIZE_MID, $urandom);
        write_cfg(bi5d_pkg::REG_TILE_SIZE_TOP, $urandom);
      end
      3: begin
        write_cfg(bi5d_pkg::REG_DATA_SIZE_LO, 32'hFFFF_FFFF);
        write_cfg(bi5d_pkg::REG_DATA_SIZE_MID, 32'hFFFF_FFFF);
        write_cfg(bi5d_pkg::REG_DATA_SIZE_TOP, 32'h0000_FFFF);
        write_cfg(bi5d_pkg::REG_TILE_SIZE_LO,
                  {16'($urandom_range(1, 4)), 16'($urandom_range(1, 4))});
        write_cfg(bi5d_pkg::REG_TILE_SIZE_MID,
                  {16'($urandom_range(1, 4)), 16'($urandom_range(1, 4))});
        write_cfg(bi5d_pkg::REG_TILE_SIZE_TOP, $urandom_range(1, 4));
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [CB-1:0] crd[5];
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset config, extremes, then each special case
    for (int k = 0; k < 5; k++) crd[k] = '0;
    send_request(1'b0, crd);
    send_request(1'b1, crd);
    for (int k = 0; k < 5; k++) crd[k] = '1;
    send_request(1'b0, crd);
    drain();
    write_cfg(bi5d_pkg::REG_DATA_SIZE_LO, 32'hFFFF_FFFF);
    write_cfg(bi5d_pkg::REG_DATA_SIZE_MID, 32'hFFFF_FFFF);
    write_cfg(bi5d_pkg::REG_DATA_SIZE_TOP, 32'h0000_FFFF);
    send_request(1'b1, crd);
    send_request(1'b0, crd);
    for (int k = 0; k < 5; k++) crd[k] = 16'h1 << (3 * k);
    send_request(1'b0, crd);
    drain();
    write_cfg(bi5d_pkg::REG_TILE_SIZE_LO, 32'hFFFF_FFFF);
    write_cfg(bi5d_pkg::REG_TILE_SIZE_MID, 32'hFFFF_FFFF);
    write_cfg(bi5d_pkg::REG_TILE_SIZE_TOP, 32'h0000_FFFF);
    write_cfg(bi5d_pkg::REG_DIM_ORDER, 32'({3'd0, 3'd1, 3'd2, 3'd3, 3'd4}));
    send_request(1'b1, crd);
    for (int k = 0; k < 5; k++) crd[k] = '1;
    send_request(1'b0, crd);
    drain();
    write_cfg(bi5d_pkg::REG_TILE_SIZE_TOP, 32'h0);
    send_request(1'b0, crd);
    send_request(1'b1, crd);
    drain();
    write_cfg(bi5d_pkg::REG_TILE_SIZE_TOP, 32'h7);
    write_cfg(bi5d_pkg::REG_DIM_ORDER, 32'h7FFF);
    send_request(1'b0, crd);
    drain();
    write_cfg(bi5d_pkg::REG_DIM_ORDER, 32'({3'd0, 3'd0, 3'd2, 3'd3, 3'd4}));
    send_request(1'b1, crd);
    drain();
    write_cfg(bi5d_pkg::REG_DIM_ORDER, 32'(bi5d_pkg::DIM_ORDER_RST));
    write_cfg(bi5d_pkg::REG_DATA_SIZE_TOP, 32'h0);
    send_request(1'b0, crd);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      random_config(ph == 0 ? 0 : (ph % 3) + 1);
      if (ph >= 16) idle_on = 0;
      repeat (25) random_request();
      drain();
    end

    $display("Covered %0d requests (%0d block totals), %0d results checked,",
             n_req, n_mode1, sb.checked);
    $display("over random orders, sizes, zero tiles and saturating volumes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bi5d_pkg.sv
rtl/bi5d_div_pipe.sv
rtl/bi5d_accum.sv
rtl/block_index_5d_core.sv
rtl/bi5d_checker.sv
verif/block_index_5d_core_tb.sv
